// ===== rtl/note_queue_tone_player_core_macros.svh =====
// assertion macros shared by the note queue tone player
`ifndef NOTE_QUEUE_TONE_PLAYER_CORE_MACROS_SVH
`define NOTE_QUEUE_TONE_PLAYER_CORE_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define NQTP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NQTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/nqtp_pkg.sv =====
// shared types and constants of the note queue tone player
package nqtp_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;

   localparam int FREQ_W     = 16;
   localparam int DUR_W      = 16;
   localparam int STEP_W     = 10;
   localparam int ELAPSED_W  = 17;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [STEP_W-1:0]    TICK_STEP_RESET = STEP_W'(10);
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX     = {ELAPSED_W{1'b1}};

   // register index taken from the word address bit
   localparam logic CSR_IDX_TICK_STEP = 1'b0;

   typedef enum logic [1:0] {
      REQ_PUSH = 2'd0,
      REQ_TICK = 2'd1,
      REQ_STOP = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dpath_status_type;

endpackage

// ===== rtl/nqtp_ctrl.sv =====
// controller state machine: accept a transaction, then commit its update
module nqtp_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  nqtp_pkg::dpath_status_type  status,
   output nqtp_pkg::ctrl_cmd_type      cmd
);

   nqtp_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         nqtp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = nqtp_pkg::ST_EXEC;
            end
         end
         nqtp_pkg::ST_EXEC: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = nqtp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nqtp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nqtp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/nqtp_dpath.sv =====
// datapath: note store, playback state, tick step register and result register
module nqtp_dpath #(
   parameter int QUEUE_DEPTH = nqtp_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int FILL_W      = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  nqtp_pkg::ctrl_cmd_type               cmd,
   output nqtp_pkg::dpath_status_type           status,
   input  logic [1:0]                           req_type,
   input  logic [nqtp_pkg::FREQ_W-1:0]          req_note_freq,
   input  logic [nqtp_pkg::DUR_W-1:0]           req_note_duration,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_push_accepted,
   output logic                                 rsp_tone_on,
   output logic [nqtp_pkg::FREQ_W-1:0]          rsp_tone_freq,
   output logic                                 rsp_busy_res,
   output logic [FILL_W-1:0]                    rsp_queue_fill,
   input  logic                                 csr_write,
   input  logic [nqtp_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [nqtp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic [nqtp_pkg::CSR_DATA_W-1:0]      csr_rdata
);

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int ENTRY_W = nqtp_pkg::FREQ_W + nqtp_pkg::DUR_W;
   localparam int SUM_W   = nqtp_pkg::ELAPSED_W + 1;

   logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [1:0]                    type_ff;
   logic [nqtp_pkg::FREQ_W-1:0]   freq_ff;
   logic [nqtp_pkg::DUR_W-1:0]    dur_ff;

   logic [PTR_W-1:0]               rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [FILL_W-1:0]              fill_ff, fill_in;
   logic [nqtp_pkg::DUR_W-1:0]     play_dur_ff, play_dur_in;
   logic [nqtp_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                           buz_on_ff, buz_on_in;
   logic [nqtp_pkg::FREQ_W-1:0]    buz_freq_ff, buz_freq_in;
   logic [nqtp_pkg::STEP_W-1:0]    step_ff;
   logic                           accepted;
   logic                           store_write;
   logic [SUM_W-1:0]               sum;
   logic [nqtp_pkg::ELAPSED_W-1:0] sat;
   logic [nqtp_pkg::FREQ_W-1:0]    head_freq;
   logic                           rsp_valid_ff;

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign csr_rdata = {{(nqtp_pkg::CSR_DATA_W - nqtp_pkg::STEP_W){1'b0}}, step_ff};

   assign head_freq = rd_data_ff[ENTRY_W-1:nqtp_pkg::DUR_W];
   assign sum = {1'b0, elapsed_ff} + SUM_W'(step_ff);
   assign sat = (sum > SUM_W'(nqtp_pkg::ELAPSED_MAX)) ? nqtp_pkg::ELAPSED_MAX
                                                       : sum[nqtp_pkg::ELAPSED_W-1:0];

   always_comb begin
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      fill_in     = fill_ff;
      play_dur_in = play_dur_ff;
      elapsed_in  = elapsed_ff;
      buz_on_in   = buz_on_ff;
      buz_freq_in = buz_freq_ff;
      accepted    = 1'b0;
      store_write = 1'b0;
      unique case (type_ff)
         nqtp_pkg::REQ_PUSH: begin
            if (fill_ff < FILL_W'(QUEUE_DEPTH)) begin
               store_write = 1'b1;
               accepted    = 1'b1;
               fill_in     = fill_ff + 1'b1;
               wr_ptr_in   = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
            end
         end
         nqtp_pkg::REQ_TICK: begin
            if (play_dur_ff == '0) begin
               if (fill_ff != '0) begin
                  play_dur_in = rd_data_ff[nqtp_pkg::DUR_W-1:0];
                  rd_ptr_in   = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_ff + 1'b1;
                  fill_in     = fill_ff - 1'b1;
                  elapsed_in  = '0;
                  buz_on_in   = (head_freq != '0);
                  buz_freq_in = head_freq;
               end else begin
                  buz_on_in   = 1'b0;
                  buz_freq_in = '0;
               end
            end else begin
               elapsed_in = sat;
               if (sat >= nqtp_pkg::ELAPSED_W'(play_dur_ff)) begin
                  buz_on_in   = 1'b0;
                  buz_freq_in = '0;
                  play_dur_in = '0;
               end
            end
         end
         nqtp_pkg::REQ_STOP: begin
            rd_ptr_in   = '0;
            wr_ptr_in   = '0;
            fill_in     = '0;
            play_dur_in = '0;
            elapsed_in  = '0;
            buz_on_in   = 1'b0;
            buz_freq_in = '0;
         end
         default: begin
         end
      endcase
   end

   // note store and its registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit && store_write) begin
         mem[wr_ptr_ff] <= {freq_ff, dur_ff};
      end
      rd_data_ff <= mem[rd_ptr_ff];
   end

   // captured transaction and result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         freq_ff <= req_note_freq;
         dur_ff  <= req_note_duration;
      end
      if (cmd.commit) begin
         rsp_push_accepted <= accepted;
         rsp_tone_on       <= buz_on_in;
         rsp_tone_freq     <= buz_on_in ? buz_freq_in : '0;
         rsp_busy_res      <= (fill_in != '0) || (play_dur_in != '0);
         rsp_queue_fill    <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         play_dur_ff  <= '0;
         elapsed_ff   <= '0;
         buz_on_ff    <= 1'b0;
         buz_freq_ff  <= '0;
         step_ff      <= nqtp_pkg::TICK_STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rd_ptr_ff   <= rd_ptr_in;
            wr_ptr_ff   <= wr_ptr_in;
            fill_ff     <= fill_in;
            play_dur_ff <= play_dur_in;
            elapsed_ff  <= elapsed_in;
            buz_on_ff   <= buz_on_in;
            buz_freq_ff <= buz_freq_in;
         end
         if (csr_write && (csr_addr[2] == nqtp_pkg::CSR_IDX_TICK_STEP)) begin
            step_ff <= csr_wdata[nqtp_pkg::STEP_W-1:0];
         end
         rsp_valid_ff <= cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      end
   end

endmodule

// ===== rtl/note_queue_tone_player_core.sv =====
// note queue tone player: a note fifo that sequences a buzzer tone, one result per
// transaction. each request transaction is accepted, then committed from the registered
// read of the note store; the commit waits while the previous result still sits unread
// in the result register. a push stores a note unless the fifo is full, a tick pops the
// head note when nothing plays or advances elapsed time by tick_step_ms (saturating), a
// stop clears the fifo and the note. the tick step lives at csr byte address 0; the user
// must write it only while the block is idle; the block does not enforce this. there
// is no clearing pass after reset: the fill count guards every read of the store.
`include "note_queue_tone_player_core_macros.svh"

module note_queue_tone_player_core #(
   parameter int QUEUE_DEPTH = nqtp_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int FILL_W      = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   // request transactions
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_type,
   input  logic [nqtp_pkg::FREQ_W-1:0]      req_note_freq,
   input  logic [nqtp_pkg::DUR_W-1:0]       req_note_duration,
   // result transactions
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_push_accepted,
   output logic                             rsp_tone_on,
   output logic [nqtp_pkg::FREQ_W-1:0]      rsp_tone_freq,
   output logic                             rsp_busy_res,
   output logic [FILL_W-1:0]                rsp_queue_fill,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [nqtp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [nqtp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [nqtp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   nqtp_pkg::ctrl_cmd_type     cmd;
   nqtp_pkg::dpath_status_type status;
   logic                       csr_write;

   // zero-wait register port, written in the access phase
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // sequencing of accept and commit
   nqtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // note store, playback state and result register
   nqtp_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .FILL_W      (FILL_W)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_type          (req_type),
      .req_note_freq     (req_note_freq),
      .req_note_duration (req_note_duration),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_push_accepted (rsp_push_accepted),
      .rsp_tone_on       (rsp_tone_on),
      .rsp_tone_freq     (rsp_tone_freq),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_queue_fill    (rsp_queue_fill),
      .csr_write         (csr_write),
      .csr_addr          (csr_paddr),
      .csr_wdata         (csr_pwdata),
      .csr_rdata         (csr_prdata)
   );

   // fill reported never exceeds the queue depth
   `NQTP_ASSERT_NOW(a_fill_bound, clock, reset, rsp_valid, rsp_queue_fill <= FILL_W'(QUEUE_DEPTH), "queue fill above depth")
   // a stored push leaves the player busy
   `NQTP_ASSERT_NOW(a_push_busy, clock, reset, rsp_valid && rsp_push_accepted, rsp_busy_res, "push stored but not busy")
   // a sounding tone has a nonzero frequency; a zero-length note may leave it on while idle
   `NQTP_ASSERT_NOW(a_tone_state, clock, reset, rsp_valid && rsp_tone_on, rsp_tone_freq != '0, "tone on at zero freq")
   // an accepted transaction blocks the request side for its commit cycle
   `NQTP_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready, "request taken during commit")

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the note queue tone player core
module testbench;

   localparam int DEPTH        = nqtp_pkg::DEFAULT_QUEUE_DEPTH;
   localparam int FILL_W       = $clog2(DEPTH + 1);
   localparam int PTR_W        = $clog2(DEPTH);
   localparam int FREQ_W       = nqtp_pkg::FREQ_W;
   localparam int DUR_W        = nqtp_pkg::DUR_W;
   localparam int STEP_W       = nqtp_pkg::STEP_W;
   localparam int ELAPSED_W    = nqtp_pkg::ELAPSED_W;
   localparam int CSR_ADDR_W   = nqtp_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W   = nqtp_pkg::CSR_DATA_W;
   localparam int REPORT_LIMIT = 10;
   localparam int PLAN_ROWS    = 23;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 100;

   localparam logic [1:0] REQ_PUSH = nqtp_pkg::REQ_PUSH;
   localparam logic [1:0] REQ_TICK = nqtp_pkg::REQ_TICK;
   localparam logic [1:0] REQ_STOP = nqtp_pkg::REQ_STOP;
   // request code the block ignores apart from reporting its status
   localparam logic [1:0] REQ_IGNORED = 2'd3;
   // tick step register, the only one on the csr port
   localparam logic [CSR_ADDR_W-1:0] TICK_STEP_ADDR = '0;

   typedef struct packed {
      logic              accepted;
      logic              tone_on;
      logic [FREQ_W-1:0] tone_freq;
      logic              busy;
      logic [FILL_W-1:0] fill;
   } tone_status_type;

   localparam tone_status_type STATUS_IDLE = '0;

   // one row of the directed sequence; want is only used where known is set
   typedef struct packed {
      logic [1:0]        kind;
      logic [FREQ_W-1:0] freq;
      logic [DUR_W-1:0]  dur;
      logic [4:0]        reps;
      logic              known;
      tone_status_type   want;
   } plan_row_type;

   // ---------------------------------------------------------------------------
   // clock, reset and block inputs, all known from time zero
   // ---------------------------------------------------------------------------
   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_type          = '0;
   logic [FREQ_W-1:0]     req_note_freq     = '0;
   logic [DUR_W-1:0]      req_note_duration = '0;
   logic                  rsp_valid;
   logic                  rsp_ready         = 1'b0;
   logic                  rsp_push_accepted;
   logic                  rsp_tone_on;
   logic [FREQ_W-1:0]     rsp_tone_freq;
   logic                  rsp_busy_res;
   logic [FILL_W-1:0]     rsp_queue_fill;
   logic                  csr_psel          = 1'b0;
   logic                  csr_penable       = 1'b0;
   logic                  csr_pwrite        = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr         = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata        = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   note_queue_tone_player_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_note_freq     (req_note_freq),
      .req_note_duration (req_note_duration),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_push_accepted (rsp_push_accepted),
      .rsp_tone_on       (rsp_tone_on),
      .rsp_tone_freq     (rsp_tone_freq),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_queue_fill    (rsp_queue_fill),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // ---------------------------------------------------------------------------
   // player model: its own copy of the fifo, the playing note and the buzzer
   // ---------------------------------------------------------------------------
   logic [FREQ_W+DUR_W-1:0] note_mem [DEPTH];
   logic [PTR_W-1:0]        rd_ptr    = '0;
   logic [PTR_W-1:0]        wr_ptr    = '0;
   logic [FILL_W-1:0]       fill      = '0;
   logic [FREQ_W-1:0]       play_freq = '0;
   logic [DUR_W-1:0]        play_dur  = '0;
   logic [ELAPSED_W-1:0]    elapsed   = '0;
   logic                    buzz_on   = 1'b0;
   logic [FREQ_W-1:0]       buzz_freq = '0;
   logic [STEP_W-1:0]       step      = nqtp_pkg::TICK_STEP_RESET;

   // statuses still owed by the block, oldest first
   tone_status_type status_q [$];
   int              mismatches   = 0;
   int              snd_idle_pct = 0;
   int              rcv_idle_pct = 0;

   // apply one accepted transaction to the model and return the status it reports
   function automatic tone_status_type advance_player(logic [1:0] kind,
                                                      logic [FREQ_W-1:0] freq,
                                                      logic [DUR_W-1:0] dur);
      tone_status_type         s;
      logic [ELAPSED_W:0]      sum;
      logic [FREQ_W+DUR_W-1:0] entry;
      s = '0;
      unique case (kind)
         REQ_PUSH: begin
            // a full fifo drops the note
            if (fill < DEPTH) begin
               note_mem[wr_ptr] = {freq, dur};
               wr_ptr = wr_ptr + 1'b1;
               fill = fill + 1'b1;
               s.accepted = 1'b1;
            end
         end
         REQ_TICK: begin
            if (play_dur == '0) begin
               if (fill != '0) begin
                  // pop the head note; a rest keeps the buzzer quiet but is still timed
                  entry = note_mem[rd_ptr];
                  play_freq = entry[FREQ_W+DUR_W-1:DUR_W];
                  play_dur = entry[DUR_W-1:0];
                  rd_ptr = rd_ptr + 1'b1;
                  fill = fill - 1'b1;
                  elapsed = '0;
                  buzz_on = (play_freq != '0);
                  buzz_freq = play_freq;
               end else begin
                  buzz_on = 1'b0;
                  buzz_freq = '0;
               end
            end else begin
               // elapsed time saturates instead of wrapping
               sum = {1'b0, elapsed} + step;
               if (sum > nqtp_pkg::ELAPSED_MAX) sum = nqtp_pkg::ELAPSED_MAX;
               elapsed = sum[ELAPSED_W-1:0];
               if (elapsed >= play_dur) begin
                  buzz_on = 1'b0;
                  buzz_freq = '0;
                  play_dur = '0;
               end
            end
         end
         REQ_STOP: begin
            rd_ptr = '0;
            wr_ptr = '0;
            fill = '0;
            play_freq = '0;
            play_dur = '0;
            elapsed = '0;
            buzz_on = 1'b0;
            buzz_freq = '0;
         end
         default: ;
      endcase
      s.tone_on = buzz_on;
      s.tone_freq = buzz_on ? buzz_freq : '0;
      s.busy = (fill != '0) || (play_dur != '0);
      s.fill = fill;
      return s;
   endfunction

   function automatic void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", msg);
   endfunction

   // ---------------------------------------------------------------------------
   // result side: random stalls, every transaction checked against the oldest status
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      tone_status_type got;
      tone_status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_push_accepted, rsp_tone_on, rsp_tone_freq, rsp_busy_res, rsp_queue_fill};
         if (status_q.size() == 0) begin
            flag_mismatch($sformatf({"result with nothing outstanding: ",
                                     "acc=%0d on=%0d freq=%0d busy=%0d fill=%0d"},
                                    got.accepted, got.tone_on, got.tone_freq, got.busy,
                                    got.fill));
         end else begin
            want = status_q.pop_front();
            if (got !== want)
               flag_mismatch($sformatf({"expected acc=%0d on=%0d freq=%0d busy=%0d fill=%0d, ",
                                        "got acc=%0d on=%0d freq=%0d busy=%0d fill=%0d"},
                                       want.accepted, want.tone_on, want.tone_freq, want.busy,
                                       want.fill, got.accepted, got.tone_on, got.tone_freq,
                                       got.busy, got.fill));
         end
      end
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // ---------------------------------------------------------------------------
   // request side and csr port
   // ---------------------------------------------------------------------------

   // offer one request, idling at random first; valid is left high for the next one
   task automatic send_request(logic [1:0] kind, logic [FREQ_W-1:0] freq,
                               logic [DUR_W-1:0] dur, logic known, tone_status_type want);
      tone_status_type predicted;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_note_freq     <= freq;
      req_note_duration <= dur;
      do @(posedge clock); while (!req_ready);
      predicted = advance_player(kind, freq, dur);
      // typed-in rows take precedence, the model still tracks the state
      status_q.push_back(known ? want : predicted);
   endtask

   // hold off new requests until every owed result has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (status_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(logic [CSR_ADDR_W-1:0] addr, output logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // change the tick step with the block idle, junk in the unused upper bits, then read back
   task automatic set_tick_step(logic [STEP_W-1:0] value);
      logic [CSR_DATA_W-1:0] wdata;
      logic [CSR_DATA_W-1:0] readback;
      wait_for_drain();
      wdata = $urandom;
      wdata[STEP_W-1:0] = value;
      csr_write(TICK_STEP_ADDR, wdata);
      step = value;
      csr_read(TICK_STEP_ADDR, readback);
      if (readback !== CSR_DATA_W'(value))
         flag_mismatch($sformatf("tick step readback expected %0d, got %0d", value, readback));
   endtask

   // ---------------------------------------------------------------------------
   // directed sequence, tick step at its reset value of 10
   // ---------------------------------------------------------------------------
   plan_row_type tone_plan [PLAN_ROWS] = '{
      // tick, ignored code and stop straight after reset: all quiet
      '{REQ_TICK,    16'h0000, 16'h0000, 5'd1,  1'b1, STATUS_IDLE},
      '{REQ_IGNORED, 16'hffff, 16'hffff, 5'd1,  1'b1, STATUS_IDLE},
      '{REQ_STOP,    16'hffff, 16'hffff, 5'd1,  1'b1, STATUS_IDLE},
      // top frequency, a rest and a zero-length note
      '{REQ_PUSH,    16'hffff, 16'd20,   5'd1,  1'b1, '{1'b1, 1'b0, 16'd0, 1'b1, 5'd1}},
      '{REQ_PUSH,    16'h0000, 16'd10,   5'd1,  1'b1, '{1'b1, 1'b0, 16'd0, 1'b1, 5'd2}},
      '{REQ_PUSH,    16'h0001, 16'd0,    5'd1,  1'b1, '{1'b1, 1'b0, 16'd0, 1'b1, 5'd3}},
      '{REQ_TICK,    16'h0000, 16'h0000, 5'd1,  1'b1, '{1'b0, 1'b1, 16'hffff, 1'b1, 5'd2}},
      // note times out, rest plays silently, zero-length note pops and is gone
      '{REQ_TICK,    16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_IDLE},
      '{REQ_TICK,    16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_IDLE},
      '{REQ_TICK,    16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_IDLE},
      '{REQ_TICK,    16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_IDLE},
      '{REQ_TICK,    16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_IDLE},
      '{REQ_TICK,    16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_IDLE},
      // fill the fifo, then a push on full is dropped
      '{REQ_PUSH,    16'h1234, 16'hffff, 5'd16, 1'b0, STATUS_IDLE},
      '{REQ_PUSH,    16'hffff, 16'hffff, 5'd1,  1'b1, '{1'b0, 1'b0, 16'd0, 1'b1, 5'd16}},
      '{REQ_TICK,    16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_IDLE},
      '{REQ_IGNORED, 16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_IDLE},
      '{REQ_PUSH,    16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_IDLE},
      // dropped push while the popped note still sounds
      '{REQ_PUSH,    16'h0000, 16'h0000, 5'd1,  1'b1, '{1'b0, 1'b1, 16'h1234, 1'b1, 5'd16}},
      // stop clears everything, including the playing note
      '{REQ_STOP,    16'h0000, 16'h0000, 5'd1,  1'b1, STATUS_IDLE},
      '{REQ_PUSH,    16'h0000, 16'hffff, 5'd1,  1'b0, STATUS_IDLE},
      '{REQ_TICK,    16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_IDLE},
      '{REQ_STOP,    16'h0000, 16'h0000, 5'd1,  1'b0, STATUS_IDLE}
   };

   // tick steps of the random phases: smallest nonzero, largest, zero, 1000, random, reset
   logic [STEP_W-1:0] phase_step [PHASES] = '{10'd1, 10'd1023, 10'd0, 10'd1000, 10'd0, 10'd10};

   initial begin
      logic [CSR_DATA_W-1:0] readback;
      logic [1:0]            kind;
      logic [FREQ_W-1:0]     freq;
      logic [DUR_W-1:0]      dur;
      int                    roll;
      int                    push_pct;
      int                    span;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tick step must come up at its reset value
      csr_read(TICK_STEP_ADDR, readback);
      if (readback !== CSR_DATA_W'(nqtp_pkg::TICK_STEP_RESET))
         flag_mismatch($sformatf("tick step after reset expected %0d, got %0d",
                                 nqtp_pkg::TICK_STEP_RESET, readback));

      snd_idle_pct = 12;
      rcv_idle_pct = 68;
      for (int r = 0; r < PLAN_ROWS; r++) begin
         for (int k = 0; k < tone_plan[r].reps; k++)
            send_request(tone_plan[r].kind, tone_plan[r].freq, tone_plan[r].dur,
                         tone_plan[r].known, tone_plan[r].want);
      end

      // random phases; idling pattern moves on every two phases
      push_pct = 50;
      for (int p = 0; p < PHASES; p++) begin
         unique case (p / 2)
            0: begin snd_idle_pct = 12; rcv_idle_pct = 68; end
            1: begin snd_idle_pct = 68; rcv_idle_pct = 12; end
            default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
         endcase
         set_tick_step(p == 4 ? STEP_W'($urandom_range(2, 999)) : phase_step[p]);
         span = 4 * int'(step) + 1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // halfway through, let the block run dry before carrying on
            if (i == PHASE_ITEMS / 2) wait_for_drain();
            // shift the push/tick balance now and then so the fifo swings empty to full
            if (i % 25 == 0) push_pct = $urandom_range(30, 65);
            roll = $urandom_range(99);
            if (roll < push_pct) kind = REQ_PUSH;
            else if (roll < 94)  kind = REQ_TICK;
            else if (roll < 97)  kind = REQ_STOP;
            else                 kind = REQ_IGNORED;
            // rests and the top frequency turn up often
            roll = $urandom_range(9);
            if (roll < 2)       freq = '0;
            else if (roll == 2) freq = '1;
            else                freq = FREQ_W'($urandom);
            // mostly durations that end within a few ticks, some zero or very long
            roll = $urandom_range(19);
            if (roll < 2)       dur = '0;
            else if (roll == 2) dur = '1;
            else if (roll < 17) dur = DUR_W'($urandom_range(1, span));
            else                dur = DUR_W'($urandom);
            send_request(kind, freq, dur, 1'b0, STATUS_IDLE);
         end
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && status_q.size() == 0) begin
         $display("PASS note_queue_tone_player_core");
      end else begin
         $display("FAIL note_queue_tone_player_core");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("FAIL note_queue_tone_player_core");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/nqtp_pkg.sv
rtl/nqtp_ctrl.sv
rtl/nqtp_dpath.sv
rtl/note_queue_tone_player_core.sv
dv/testbench.sv
